/* design/kli_pkg.sv */
`timescale 1ns / 1ps

package kli_pkg;

    // Fixed field widths
    localparam int Q_W         = 32;   // signed Q16.16 time and value
    localparam int FRAC_W      = 16;   // interpolation fraction bits
    localparam int KEY_TOTAL_W = 5;    // reported key count
    localparam int DIFF_W      = Q_W + 1;
    localparam int PROD_W      = DIFF_W + FRAC_W + 1;
    localparam int STEP_W      = $clog2(FRAC_W + 1);

    // Request kinds
    typedef enum logic {
        KIND_SET  = 1'b0,
        KIND_EVAL = 1'b1
    } kli_kind_t;

    // One table entry
    typedef struct packed {
        logic signed [Q_W-1:0] key_time;
        logic signed [Q_W-1:0] key_value;
    } kli_key_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FLUSH,
        ST_INSERT,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } kli_state_t;

endpackage

/* design/kli_req_if.sv */
`timescale 1ns / 1ps

interface kli_req_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic signed [kli_pkg::Q_W-1:0]   time_req;
    logic signed [kli_pkg::Q_W-1:0]   value;

    modport source (output valid, output kind, output time_req, output value, input ready);
    modport sink   (input valid, input kind, input time_req, input value, output ready);
endinterface

/* design/kli_rsp_if.sv */
`timescale 1ns / 1ps

interface kli_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [kli_pkg::Q_W-1:0]        result_value;
    logic        [kli_pkg::KEY_TOTAL_W-1:0] key_total;
    logic                                  dropped;

    modport source (output valid, output result_value, output key_total, output dropped,
                    input ready);
    modport sink   (input valid, input result_value, input key_total, input dropped,
                    output ready);
endinterface

/* design/keyframe_linear_interpolator_unit.sv */
`timescale 1ns / 1ps
// Set: a linear scan of the key table, then for an insert a one-entry-per-cycle shift through
//   the key RAM (one write port, one read port) and the write of the new key.
// Evaluate: an empty table skips the scan; else a scan, then for an inner interval a serial
//   fraction divide and a multiply step.
// One request in flight: the next is taken only after the result has moved into the output
//   register. Reset clears the state, key count and output valid, not the key RAM.

module keyframe_linear_interpolator_unit #(
    parameter int MAX_KEYS = 16
) (
    input  logic clk,
    input  logic rst_n,
    kli_req_if.sink   req,
    kli_rsp_if.source rsp
);
    import kli_pkg::*;

    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam int CNT_W = $clog2(MAX_KEYS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEYS);

    kli_state_t state_reg, state_next;

    logic [CNT_W-1:0]          count_reg, count_next;
    kli_kind_t                 kind_reg,  kind_next;
    logic signed [Q_W-1:0]     t_reg,     t_next;
    logic signed [Q_W-1:0]     v_reg,     v_next;
    logic [CNT_W-1:0]          chk_reg,   chk_next;
    kli_key_t                  prev_reg,  prev_next;
    logic [CNT_W-1:0]          sh_reg,    sh_next;
    logic [CNT_W-1:0]          pos_reg,   pos_next;
    logic                      pend_reg,  pend_next;
    logic [IDX_W-1:0]          wa_reg,    wa_next;
    logic signed [Q_W-1:0]     res_reg,   res_next;
    logic                      drop_reg,  drop_next;
    logic signed [Q_W-1:0]     base_reg,  base_next;
    logic signed [DIFF_W-1:0]  diff_reg,  diff_next;
    logic signed [PROD_W-1:0]  prod_reg,  prod_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [Q_W-1:0]     out_res_reg,   out_res_next;
    logic [KEY_TOTAL_W-1:0]    out_cnt_reg,   out_cnt_next;
    logic                      out_drop_reg,  out_drop_next;

    // RAM and divider hookup
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    kli_key_t          wr_data;
    logic [IDX_W-1:0]  rd_addr;
    kli_key_t          rd_key;
    logic              div_start;
    logic [Q_W-1:0]    div_num;
    logic [Q_W-1:0]    div_den;
    logic              div_done;
    logic [FRAC_W-1:0] div_quot;

    // Scan compare
    logic             accept;
    logic             out_free;
    logic [CNT_W-1:0] chk_inc;
    logic [CNT_W-1:0] sh_inc;
    logic             hit_eq;
    logic             hit_gt;
    logic             stop_hit;
    logic             at_last;
    logic             full;
    kli_key_t         new_key;

    assign accept   = req.valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;
    assign chk_inc  = chk_reg + 1'b1;
    assign sh_inc   = sh_reg + 1'b1;
    assign hit_eq   = (rd_key.key_time == t_reg);
    assign hit_gt   = ($signed(rd_key.key_time) > $signed(t_reg));
    assign stop_hit = (kind_reg == KIND_EVAL) ? hit_gt : (hit_gt || hit_eq);
    assign at_last  = (chk_reg == count_reg - 1'b1);
    assign full     = (count_reg == MAX_CNT);
    assign new_key  = '{key_time: t_reg, key_value: v_reg};

    // Interval widths for the fraction divide
    assign div_num = t_reg - prev_reg.key_time;
    assign div_den = rd_key.key_time - prev_reg.key_time;

    kli_key_ram #(
        .DEPTH  (MAX_KEYS),
        .ADDR_W (IDX_W)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_key)
    );

    kli_frac_div u_frac_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg == '0)
                    begin
                        state_next = (kli_kind_t'(req.kind) == KIND_EVAL) ? ST_DONE : ST_INSERT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (stop_hit)
                begin
                    if (kind_reg == KIND_EVAL)
                    begin
                        state_next = (chk_reg == '0) ? ST_DONE : ST_DIV;
                    end
                    else if (hit_eq || full)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
                else if (at_last)
                begin
                    if (kind_reg == KIND_EVAL || full)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (sh_reg == pos_reg)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:  state_next = ST_INSERT;
            ST_INSERT: state_next = ST_DONE;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs: RAM ports, divider start, request ready
    always_comb
    begin
        req.ready = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = new_key;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_SCAN:
            begin
                rd_addr = chk_inc[IDX_W-1:0];
                if (kind_reg == KIND_SET && stop_hit && hit_eq)
                begin
                    wr_en   = 1'b1;
                    wr_addr = chk_reg[IDX_W-1:0];
                end
                if (kind_reg == KIND_EVAL && stop_hit && chk_reg != '0)
                begin
                    div_start = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                rd_addr = sh_reg[IDX_W-1:0];
                wr_en   = pend_reg;
                wr_addr = wa_reg;
                wr_data = rd_key;
            end
            ST_FLUSH:
            begin
                wr_en   = 1'b1;
                wr_addr = wa_reg;
                wr_data = rd_key;
            end
            ST_INSERT:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg[IDX_W-1:0];
            end
            ST_DIV, ST_MUL, ST_DONE:
            begin
                rd_addr = '0;
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    // Datapath register updates
    always_comb
    begin
        count_next     = count_reg;
        kind_next      = kind_reg;
        t_next         = t_reg;
        v_next         = v_reg;
        chk_next       = chk_reg;
        prev_next      = prev_reg;
        sh_next        = sh_reg;
        pos_next       = pos_reg;
        pend_next      = pend_reg;
        wa_next        = wa_reg;
        res_next       = res_reg;
        drop_next      = drop_reg;
        base_next      = base_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_res_next   = out_res_reg;
        out_cnt_next   = out_cnt_reg;
        out_drop_next  = out_drop_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = kli_kind_t'(req.kind);
                    t_next    = req.time_req;
                    v_next    = req.value;
                    chk_next  = '0;
                    pos_next  = '0;
                    pend_next = 1'b0;
                    res_next  = '0;
                    drop_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (stop_hit)
                begin
                    if (kind_reg == KIND_EVAL)
                    begin
                        // First key already past the query: hold the first value; else load base and difference
                        res_next  = rd_key.key_value;
                        base_next = prev_reg.key_value;
                        diff_next = {rd_key.key_value[Q_W-1], rd_key.key_value}
                                  - {prev_reg.key_value[Q_W-1], prev_reg.key_value};
                    end
                    else if (!hit_eq)
                    begin
                        if (full)
                        begin
                            drop_next = 1'b1;
                        end
                        else
                        begin
                            pos_next = chk_reg;
                            sh_next  = count_reg - 1'b1;
                        end
                    end
                end
                else if (at_last)
                begin
                    // Query at or after the last key, or append a new last key (dropped when full)
                    if (kind_reg == KIND_EVAL)
                    begin
                        res_next = rd_key.key_value;
                    end
                    else if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = count_reg;
                    end
                end
                else
                begin
                    prev_next = rd_key;
                    chk_next  = chk_inc;
                end
            end
            ST_SHIFT:
            begin
                pend_next = 1'b1;
                wa_next   = sh_inc[IDX_W-1:0];
                sh_next   = sh_reg - 1'b1;
            end
            ST_INSERT:
            begin
                count_next = count_reg + 1'b1;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    prod_next = diff_reg * $signed({1'b0, div_quot});
                end
            end
            ST_MUL:
            begin
                // a + floor((b - a) * u / 2^16); exact result fits Q_W bits
                res_next = base_reg + prod_reg[FRAC_W+Q_W-1:FRAC_W];
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_cnt_next   = KEY_TOTAL_W'(count_reg);
                    out_drop_next  = drop_reg;
                end
            end
            default:
            begin
                pend_next = pend_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        t_reg        <= t_next;
        v_reg        <= v_next;
        chk_reg      <= chk_next;
        prev_reg     <= prev_next;
        sh_reg       <= sh_next;
        pos_reg      <= pos_next;
        wa_reg       <= wa_next;
        res_reg      <= res_next;
        drop_reg     <= drop_next;
        base_reg     <= base_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        out_res_reg  <= out_res_next;
        out_cnt_reg  <= out_cnt_next;
        out_drop_reg <= out_drop_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_res_reg;
    assign rsp.key_total    = out_cnt_reg;
    assign rsp.dropped      = out_drop_reg;

    // Key count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("key count above table size");

    // Key count moves only through an insert, by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg) != ST_INSERT |-> $stable(count_reg))
        else $error("key count changed outside insert");

    // A dropped set only happens with a full table
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.dropped |-> rsp.key_total == KEY_TOTAL_W'(MAX_KEYS))
        else $error("dropped set with room in table");

    // Divider finishes only while the sequencer waits on it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside divide wait");

endmodule

/* design/kli_key_ram.sv */
`timescale 1ns / 1ps

module kli_key_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  kli_pkg::kli_key_t wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output kli_pkg::kli_key_t rd_data
);
    import kli_pkg::*;

    kli_key_t mem [DEPTH];
    kli_key_t rd_data_reg;

    // Single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/kli_frac_div.sv */
`timescale 1ns / 1ps

// Restoring divider: quot = floor(num * 2^FRAC_W / den), num < den.
// One quotient bit per cycle.
module kli_frac_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [kli_pkg::Q_W-1:0]       num,
    input  logic [kli_pkg::Q_W-1:0]       den,
    output logic                          done,
    output logic [kli_pkg::FRAC_W-1:0]    quot
);
    import kli_pkg::*;

    logic [Q_W-1:0]    rem_reg,  rem_next;
    logic [Q_W-1:0]    den_reg,  den_next;
    logic [FRAC_W-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [Q_W:0]      rem_dbl;
    logic [Q_W:0]      rem_sub;
    logic              q_bit;

    // Shift-compare-subtract step
    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_sub = rem_dbl - {1'b0, den_reg};
    assign q_bit   = (rem_dbl >= {1'b0, den_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            cnt_next  = STEP_W'(FRAC_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = q_bit ? rem_sub[Q_W-1:0] : rem_dbl[Q_W-1:0];
            quot_next = {quot_reg[FRAC_W-2:0], q_bit};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

    // Partial remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

    // No restart while a division runs
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // Done follows the last step exactly
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && cnt_reg == STEP_W'(1) |=> done_reg && !busy_reg)
        else $error("divider done missing after last step");

endmodule
